[design/sdoc_pkg.sv]
// Shared types and constants for the expedited SDO client.
// Used by the front, queue, back and top-level modules.
`default_nettype none

package sdoc_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [6:0]  NODE_RESET    = 7'd1;

	localparam logic [10:0] COB_SDO = 11'h600;
	localparam logic [10:0] COB_PDO = 11'h200;

	localparam logic [7:0] CS_READ_REQ  = 8'h40;
	localparam logic [7:0] CS_WRITE_REQ = 8'h23;
	localparam logic [2:0] CS_READ_RSP  = 3'd2;
	localparam logic [2:0] CS_WRITE_RSP = 3'd3;
	localparam logic [1:0] CS_EXP_FLAGS = 2'b11;

	localparam logic [2:0] CMD_SDO_READ  = 3'd0;
	localparam logic [2:0] CMD_SDO_WRITE = 3'd1;
	localparam logic [2:0] CMD_FRAME     = 3'd2;
	localparam logic [2:0] CMD_TICK      = 3'd3;
	localparam logic [2:0] CMD_CLEAR     = 3'd4;
	localparam logic [2:0] CMD_PDO_WRITE = 3'd5;

	localparam logic [0:0] REG_TIMEOUT = 1'd0;
	localparam logic [0:0] REG_NODE    = 1'd1;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_FAULT = 2'd3;

	localparam logic [1:0] FLT_TIMEOUT  = 2'd0;
	localparam logic [1:0] FLT_BAD_RSP  = 2'd1;
	localparam logic [1:0] FLT_BAD_IDX  = 2'd2;
	localparam logic [1:0] FLT_BAD_SUB  = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_WRITE,
		OP_FRAME,
		OP_TICK,
		OP_CLEAR,
		OP_PDO
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] idx;
		logic [7:0]  sub;
		logic [63:0] frame;
		logic [31:0] value;
		logic        rd_cs_ok;
		logic        wr_cs_ok;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] tx_cob_id;
		logic [63:0] tx_payload;
		logic [31:0] read_value;
		logic [2:0]  fault_code;
		logic [15:0] fault_index;
		logic [7:0]  fault_subindex;
		logic [31:0] fault_value;
		logic        busy_res;
		logic        faulted;
	} res_t;

endpackage

`default_nettype wire

[design/sdoc_front.sv]
// Front end: decodes an incoming transaction into a classified item.
// Builds request frames and pre-parses received frames; uses sdoc_pkg.
`default_nettype none

module sdoc_front (
	input  wire logic [2:0]  command,
	input  wire logic [15:0] obj_index,
	input  wire logic [7:0]  obj_subindex,
	input  wire logic [31:0] data_value,
	input  wire logic [63:0] payload,
	output sdoc_pkg::item_t  item
);
	import sdoc_pkg::*;

	logic [7:0] cs;
	logic [1:0] unused_n;

	assign cs       = payload[63:56];
	assign unused_n = cs[3:2];

	always_comb begin
		item          = '0;
		item.op       = OP_NONE;
		item.idx      = obj_index;
		item.sub      = obj_subindex;
		item.rd_cs_ok = (cs[7:5] == CS_READ_RSP) && (cs[1:0] == CS_EXP_FLAGS);
		item.wr_cs_ok = (cs[7:5] == CS_WRITE_RSP);
		case (command)
			CMD_SDO_READ: begin
				item.op    = OP_READ;
				item.frame = {CS_READ_REQ, obj_index[7:0], obj_index[15:8], obj_subindex,
					32'h0};
			end
			CMD_SDO_WRITE: begin
				item.op    = OP_WRITE;
				item.frame = {CS_WRITE_REQ, obj_index[7:0], obj_index[15:8], obj_subindex,
					data_value[7:0], data_value[15:8], data_value[23:16], data_value[31:24]};
			end
			CMD_FRAME: begin
				item.op  = OP_FRAME;
				item.idx = {payload[47:40], payload[55:48]};
				item.sub = payload[39:32];
				case (unused_n)
					2'd0:    item.value = {payload[7:0], payload[15:8], payload[23:16],
						payload[31:24]};
					2'd1:    item.value = {8'h0, payload[15:8], payload[23:16], payload[31:24]};
					2'd2:    item.value = {16'h0, payload[23:16], payload[31:24]};
					default: item.value = {24'h0, payload[31:24]};
				endcase
			end
			CMD_TICK:      item.op = OP_TICK;
			CMD_CLEAR:     item.op = OP_CLEAR;
			CMD_PDO_WRITE: begin
				item.op    = OP_PDO;
				item.frame = payload;
			end
			default:       item.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

[design/sdoc_queue.sv]
// Short FIFO of classified items between front and back ends.
// Depth set by DEPTH (at least 2); uses sdoc_pkg for the item type.
`default_nettype none

module sdoc_queue #(
	parameter int unsigned DEPTH = sdoc_pkg::QueueDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sdoc_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output sdoc_pkg::item_t      head
);
	import sdoc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/sdoc_back.sv]
// Back end: transfer state, timeout counter, fault latch and output register.
// Executes one classified item per cycle while res_stall does not hold the output register; uses sdoc_pkg.
`default_nettype none

module sdoc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [0:0]      cfg_index,
	input  wire logic [15:0]     cfg_data,
	input  wire logic            item_valid,
	input  wire sdoc_pkg::item_t item,
	output logic                 item_take,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output sdoc_pkg::res_t       res
);
	import sdoc_pkg::*;

	logic [15:0] timeout_q;
	logic [6:0]  node_q;
	logic        busy_q;
	logic        is_write_q;
	logic [15:0] pend_idx_q;
	logic [7:0]  pend_sub_q;
	logic [15:0] elapsed_q;
	logic        latched_q;
	logic        res_valid_q;
	res_t        res_q;

	logic        busy_d;
	logic        is_write_d;
	logic [15:0] pend_idx_d;
	logic [7:0]  pend_sub_d;
	logic [15:0] elapsed_d;
	logic        latched_d;
	res_t        res_d;
	logic [31:0] rsp_value;

	assign item_take = item_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign rsp_value = is_write_q ? 32'h0 : item.value;

	always_comb begin
		busy_d     = busy_q;
		is_write_d = is_write_q;
		pend_idx_d = pend_idx_q;
		pend_sub_d = pend_sub_q;
		elapsed_d  = elapsed_q;
		latched_d  = latched_q;
		res_d      = '0;
		res_d.kind = KIND_NONE;
		case (item.op)
			OP_READ, OP_WRITE: begin
				if (!latched_q && !busy_q) begin
					busy_d           = 1'b1;
					is_write_d       = (item.op == OP_WRITE);
					pend_idx_d       = item.idx;
					pend_sub_d       = item.sub;
					elapsed_d        = '0;
					res_d.kind       = KIND_FRAME;
					res_d.tx_cob_id  = COB_SDO + {4'h0, node_q};
					res_d.tx_payload = item.frame;
				end
			end
			OP_FRAME: begin
				if (busy_q) begin
					busy_d               = 1'b0;
					res_d.fault_index    = pend_idx_q;
					res_d.fault_subindex = pend_sub_q;
					res_d.kind           = KIND_FAULT;
					latched_d            = 1'b1;
					if (is_write_q ? !item.wr_cs_ok : !item.rd_cs_ok) begin
						res_d.fault_code = {is_write_q, FLT_BAD_RSP};
					end else if (item.idx != pend_idx_q) begin
						res_d.fault_code  = {is_write_q, FLT_BAD_IDX};
						res_d.fault_value = rsp_value;
					end else if (item.sub != pend_sub_q) begin
						res_d.fault_code  = {is_write_q, FLT_BAD_SUB};
						res_d.fault_value = rsp_value;
					end else begin
						res_d.kind           = KIND_DONE;
						res_d.read_value     = rsp_value;
						res_d.fault_index    = '0;
						res_d.fault_subindex = '0;
						latched_d            = latched_q;
					end
				end
			end
			OP_TICK: begin
				if (busy_q) begin
					elapsed_d = (elapsed_q == 16'hffff) ? elapsed_q : elapsed_q + 16'd1;
					if (elapsed_d >= timeout_q) begin
						busy_d               = 1'b0;
						latched_d            = 1'b1;
						res_d.kind           = KIND_FAULT;
						res_d.fault_code     = {is_write_q, FLT_TIMEOUT};
						res_d.fault_index    = pend_idx_q;
						res_d.fault_subindex = pend_sub_q;
					end
				end
			end
			OP_CLEAR: latched_d = 1'b0;
			OP_PDO: begin
				if (!latched_q) begin
					res_d.kind       = KIND_FRAME;
					res_d.tx_cob_id  = COB_PDO + {4'h0, node_q};
					res_d.tx_payload = item.frame;
				end
			end
			default: ;
		endcase
		res_d.busy_res = busy_d;
		res_d.faulted  = latched_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			node_q      <= NODE_RESET;
			busy_q      <= 1'b0;
			is_write_q  <= 1'b0;
			pend_idx_q  <= '0;
			pend_sub_q  <= '0;
			elapsed_q   <= '0;
			latched_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_NODE:    node_q    <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (item_take) begin
				busy_q      <= busy_d;
				is_write_q  <= is_write_d;
				pend_idx_q  <= pend_idx_d;
				pend_sub_q  <= pend_sub_d;
				elapsed_q   <= elapsed_d;
				latched_q   <= latched_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

[design/canopen_sdo_expedited_client.sv]
// Top level of the expedited SDO client: front decode, item queue, back end.
// Depends on sdoc_pkg, sdoc_front, sdoc_queue and sdoc_back.
//
// One transaction in gives exactly one result out. While the queue is not
// full, items are taken one per cycle: the front decodes each command
// combinationally into a queue of QUEUE_DEPTH entries, and the back end
// retires one queued item per cycle into a registered output unless
// out_stall holds it, so steady throughput is one item per clock. in_stall
// rises only while the queue is full, which happens when out_stall holds
// the output register. Configuration writes take effect at the next edge
// and should be issued with no transactions in flight.
`default_nettype none

module canopen_sdo_expedited_client #(
	parameter int unsigned QUEUE_DEPTH = sdoc_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] obj_index,
	input  wire logic [7:0]  obj_subindex,
	input  wire logic [31:0] data_value,
	input  wire logic [63:0] payload,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [10:0]      tx_cob_id,
	output logic [63:0]      tx_payload,
	output logic [31:0]      read_value,
	output logic [2:0]       fault_code,
	output logic [15:0]      fault_index,
	output logic [7:0]       fault_subindex,
	output logic [31:0]      fault_value,
	output logic             busy_res,
	output logic             faulted
);
	import sdoc_pkg::*;

	item_t front_item;
	item_t head_item;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;
	res_t  res;

	sdoc_front u_front (
		.command      (command),
		.obj_index    (obj_index),
		.obj_subindex (obj_subindex),
		.data_value   (data_value),
		.payload      (payload),
		.item         (front_item)
	);

	sdoc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	sdoc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (q_not_empty),
		.item       (head_item),
		.item_take  (q_pop),
		.res_valid  (out_valid),
		.res_stall  (out_stall),
		.res        (res)
	);

	assign in_stall       = q_full;
	assign kind           = res.kind;
	assign tx_cob_id      = res.tx_cob_id;
	assign tx_payload     = res.tx_payload;
	assign read_value     = res.read_value;
	assign fault_code     = res.fault_code;
	assign fault_index    = res.fault_index;
	assign fault_subindex = res.fault_subindex;
	assign fault_value    = res.fault_value;
	assign busy_res       = res.busy_res;
	assign faulted        = res.faulted;

	a_end_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DONE || kind == KIND_FAULT) |-> !busy_res)
		else $error("transfer still busy after done or fault");

	a_fault_latches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FAULT |-> faulted)
		else $error("fault raised without latch");

	a_frame_unlatched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FRAME |-> !faulted)
		else $error("frame emitted while fault latched");

	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty && !(out_valid && out_stall))
		else $error("back end took an item without room");

endmodule

`default_nettype wire
